FILE: src/slcs_pkg.sv
// Shared types and constants of the SIR lattice contact step unit.
package slcs_pkg;

  // Item commands.
  localparam logic [1:0] CMD_STEP       = 2'd0;
  localparam logic [1:0] CMD_SITE_WRITE = 2'd1;
  localparam logic [1:0] CMD_BOND_WRITE = 2'd2;
  localparam logic [1:0] CMD_NOP        = 2'd3;

  // Site states; the fourth code is not a state and is ignored on writes.
  localparam logic [1:0] ST_SUS     = 2'd0;
  localparam logic [1:0] ST_INF     = 2'd1;
  localparam logic [1:0] ST_REM     = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Neighbour directions.
  localparam logic [1:0] DIR_Y_INC = 2'd0;
  localparam logic [1:0] DIR_X_INC = 2'd1;
  localparam logic [1:0] DIR_Y_DEC = 2'd2;
  localparam logic [1:0] DIR_X_DEC = 2'd3;

  localparam int          PROB_W          = 17;
  localparam int          COUNT_W         = 17;
  localparam logic [16:0] INFECT_PROB_RST  = 17'd65536;
  localparam logic [16:0] RECOVER_PROB_RST = 17'd13107;

  typedef enum logic {
    CFG_INFECT_PROB  = 1'b0,
    CFG_RECOVER_PROB = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_RECOVER,
    S_DONE
  } slcs_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  site_x;
    logic [7:0]  site_y;
    logic [1:0]  direction;
    logic [15:0] infect_draw;
    logic [7:0]  recover_x;
    logic [7:0]  recover_y;
    logic [15:0] recover_draw;
    logic [1:0]  write_value;
    logic [8:0]  bond_row;
    logic [7:0]  bond_col;
  } step_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] removed_count;
    logic               did_infect;
    logic               did_recover;
  } step_result_t;

  typedef struct packed {
    cfg_idx_t          index;
    logic [PROB_W-1:0] value;
  } cfg_write_t;

endpackage

FILE: src/slcs_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
interface slcs_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/slcs_lattice_store.sv
// Site state memory and bond memory with registered reads.
module slcs_lattice_store #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] site_rd_a_addr,
  input  logic [ADDR_W-1:0] site_rd_b_addr,
  output logic [1:0]        site_rd_a_data,
  output logic [1:0]        site_rd_b_data,
  input  logic              site_we,
  input  logic [ADDR_W-1:0] site_waddr,
  input  logic [1:0]        site_wdata,
  input  logic [ADDR_W-1:0] bond_raddr,
  output logic [1:0]        bond_rdata,
  input  logic              bond_we,
  input  logic [ADDR_W-1:0] bond_waddr,
  input  logic [1:0]        bond_wdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  // Each bond word holds the bonds of an even and an odd bond row.
  logic [1:0] site_mem [DEPTH];
  logic [1:0] bond_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (site_we) begin
      site_mem[site_waddr] <= site_wdata;
    end
    site_rd_a_data <= site_mem[site_rd_a_addr];
    site_rd_b_data <= site_mem[site_rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (bond_we) begin
      bond_mem[bond_waddr] <= bond_wdata;
    end
    bond_rdata <= bond_mem[bond_raddr];
  end

endmodule

FILE: src/sir_lattice_contact_step_unit.sv
// Top level of the SIR lattice contact step unit.
//
// Items arrive on in_chan, one result per item leaves on out_chan, and the two
// probability thresholds are written on cfg_chan, which is always ready.
// A step item reads the source, neighbour and bond in the cycle of its
// transfer, decides infection and reads the recovery site in the next cycle
// (S_LOOKUP), decides recovery in S_RECOVER and loads the output register in
// S_DONE once that register is free. Site writes, bond writes and no-ops
// skip S_RECOVER. Items are taken only in S_IDLE, so no new item is taken
// until the previous one has left S_DONE. Steps pass through S_RECOVER as the
// single write port of the site memory takes the infection write and the
// recovery write in successive cycles.
// After reset the unit sweeps both memories, one word per cycle; in_chan is
// not ready during the sweep, while configuration writes are taken throughout.
// A result waits in the output register while out_chan stalls; the next item
// is taken meanwhile and holds in its last cycle until the register is free.
module sir_lattice_contact_step_unit #(
  parameter int GRID_DIM = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  slcs_chan_if.sink   cfg_chan,
  slcs_chan_if.sink   in_chan,
  slcs_chan_if.source out_chan
);

  localparam int CW         = $clog2(GRID_DIM);
  localparam int SITE_COUNT = GRID_DIM * GRID_DIM;
  localparam int SAW        = $clog2(SITE_COUNT);

  function automatic logic [SAW-1:0] lin_addr(input logic [CW-1:0] row,
                                              input logic [CW-1:0] col);
    return SAW'(SAW'(row) * SAW'(GRID_DIM) + SAW'(col));
  endfunction

  slcs_pkg::slcs_state_t state_r, state_nxt;

  logic [SAW-1:0]                  clr_r;
  logic [slcs_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic [slcs_pkg::PROB_W-1:0]     infect_prob_r, recover_prob_r;
  logic                            out_valid_r, out_valid_nxt;
  slcs_pkg::step_result_t          result_r;

  // Item held while it is worked on.
  logic [1:0]     cmd_r;
  logic           src_ok_r, rec_ok_r, site_wr_ok_r, bond_wr_ok_r;
  logic [1:0]     wval_r;
  logic [15:0]    idraw_r, rdraw_r;
  logic [SAW-1:0] src_addr_r, nbr_addr_r, rec_addr_r, bond_addr_r;
  logic           bond_sel_r;
  logic           inf_r, rec_flag_r;

  // Address generation from the incoming item.
  slcs_pkg::step_item_t item;
  logic [CW-1:0]  sx, sy, nx, ny, col, rx, ry, x_inc, y_inc, x_dec, y_dec;
  logic [CW:0]    sx_p1, sy_p1, row_sum;
  logic           src_ok, rec_ok, bond_ok;
  logic [SAW-1:0] src_addr, nbr_addr, rec_addr, step_bond_addr, wr_bond_addr;
  logic [SAW-1:0] bond_addr;
  logic           bond_sel;

  // Memory controls.
  logic [SAW-1:0] site_rd_a_addr, site_waddr, bond_waddr;
  logic [1:0]     site_rd_a_data, site_rd_b_data, site_wdata;
  logic [1:0]     bond_rdata, bond_wdata;
  logic           site_we, bond_we;

  logic           accept, out_free, clr_done;
  logic           infect_now, recover_now, bond_bit;
  logic [1:0]     rec_state;

  assign item     = in_chan.data;
  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign clr_done = (clr_r == SAW'(SITE_COUNT - 1));

  assign in_chan.ready  = (state_r == slcs_pkg::S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = result_r;

  always_comb begin
    sx = CW'(item.site_x);
    sy = CW'(item.site_y);
    rx = CW'(item.recover_x);
    ry = CW'(item.recover_y);
    src_ok = (32'(item.site_x) < GRID_DIM) && (32'(item.site_y) < GRID_DIM);
    rec_ok = (32'(item.recover_x) < GRID_DIM) && (32'(item.recover_y) < GRID_DIM);
    bond_ok = (32'(item.bond_row) < 2 * GRID_DIM) && (32'(item.bond_col) < GRID_DIM);

    sx_p1 = {1'b0, sx} + (CW + 1)'(1);
    sy_p1 = {1'b0, sy} + (CW + 1)'(1);
    x_inc = (sx_p1 >= (CW + 1)'(GRID_DIM)) ? '0 : sx_p1[CW-1:0];
    y_inc = (sy_p1 >= (CW + 1)'(GRID_DIM)) ? '0 : sy_p1[CW-1:0];
    x_dec = (sx == '0) ? CW'(GRID_DIM - 1) : sx - CW'(1);
    y_dec = (sy == '0) ? CW'(GRID_DIM - 1) : sy - CW'(1);

    unique case (item.direction)
      slcs_pkg::DIR_Y_INC: begin nx = sx;    ny = y_inc; end
      slcs_pkg::DIR_X_INC: begin nx = x_inc; ny = sy;    end
      slcs_pkg::DIR_Y_DEC: begin nx = sx;    ny = y_dec; end
      default:             begin nx = x_dec; ny = sy;    end
    endcase

    col     = (ny < sy) ? ny : sy;
    row_sum = {1'b0, sx} + {1'b0, nx};

    src_addr       = lin_addr(sx, sy);
    nbr_addr       = lin_addr(nx, ny);
    rec_addr       = lin_addr(rx, ry);
    step_bond_addr = lin_addr(row_sum[CW:1], col);
    wr_bond_addr   = lin_addr(CW'(item.bond_row >> 1), CW'(item.bond_col));

    if (item.command == slcs_pkg::CMD_BOND_WRITE) begin
      bond_addr = wr_bond_addr;
      bond_sel  = item.bond_row[0];
    end else begin
      bond_addr = step_bond_addr;
      bond_sel  = row_sum[0];
    end
  end

  slcs_lattice_store #(
    .ADDR_W (SAW)
  ) u_store (
    .clk            (clk),
    .site_rd_a_addr (site_rd_a_addr),
    .site_rd_b_addr (nbr_addr),
    .site_rd_a_data (site_rd_a_data),
    .site_rd_b_data (site_rd_b_data),
    .site_we        (site_we),
    .site_waddr     (site_waddr),
    .site_wdata     (site_wdata),
    .bond_raddr     (bond_addr),
    .bond_rdata     (bond_rdata),
    .bond_we        (bond_we),
    .bond_waddr     (bond_waddr),
    .bond_wdata     (bond_wdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slcs_pkg::S_CLEAR: begin
        if (clr_done) state_nxt = slcs_pkg::S_IDLE;
      end
      slcs_pkg::S_IDLE: begin
        if (in_chan.valid) state_nxt = slcs_pkg::S_LOOKUP;
      end
      slcs_pkg::S_LOOKUP: begin
        state_nxt = (cmd_r == slcs_pkg::CMD_STEP) ? slcs_pkg::S_RECOVER : slcs_pkg::S_DONE;
      end
      slcs_pkg::S_RECOVER: begin
        state_nxt = slcs_pkg::S_DONE;
      end
      slcs_pkg::S_DONE: begin
        if (out_free) state_nxt = slcs_pkg::S_IDLE;
      end
      default: begin
        state_nxt = slcs_pkg::S_CLEAR;
      end
    endcase
  end

  // Memory controls, decisions and count.
  always_comb begin
    site_rd_a_addr = src_addr;
    site_we        = 1'b0;
    site_waddr     = src_addr_r;
    site_wdata     = slcs_pkg::ST_SUS;
    bond_we        = 1'b0;
    bond_waddr     = bond_addr_r;
    bond_wdata     = bond_rdata;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;

    bond_bit   = bond_sel_r ? bond_rdata[1] : bond_rdata[0];
    infect_now = (cmd_r == slcs_pkg::CMD_STEP) && src_ok_r &&
                 (site_rd_a_data == slcs_pkg::ST_INF) &&
                 (site_rd_b_data == slcs_pkg::ST_SUS) &&
                 (infect_prob_r > {1'b0, idraw_r}) && !bond_bit;

    // The recovery site may be the neighbour infected in S_LOOKUP, whose write the
    // registered read of the recovery site did not yet see.
    rec_state   = (inf_r && (rec_addr_r == nbr_addr_r)) ? slcs_pkg::ST_INF : site_rd_a_data;
    recover_now = rec_ok_r && (rec_state == slcs_pkg::ST_INF) &&
                  (recover_prob_r > {1'b0, rdraw_r});

    unique case (state_r)
      slcs_pkg::S_CLEAR: begin
        site_we    = 1'b1;
        site_waddr = clr_r;
        site_wdata = slcs_pkg::ST_SUS;
        bond_we    = 1'b1;
        bond_waddr = clr_r;
        bond_wdata = 2'b00;
      end
      slcs_pkg::S_IDLE: begin
        site_rd_a_addr = src_addr;
      end
      slcs_pkg::S_LOOKUP: begin
        site_rd_a_addr = rec_addr_r;
        if (infect_now) begin
          site_we    = 1'b1;
          site_waddr = nbr_addr_r;
          site_wdata = slcs_pkg::ST_INF;
        end else if (site_wr_ok_r) begin
          site_we    = 1'b1;
          site_waddr = src_addr_r;
          site_wdata = wval_r;
          if ((site_rd_a_data == slcs_pkg::ST_REM) && (wval_r != slcs_pkg::ST_REM)) begin
            count_nxt = count_r - slcs_pkg::COUNT_W'(1);
          end else if ((site_rd_a_data != slcs_pkg::ST_REM) &&
                       (wval_r == slcs_pkg::ST_REM)) begin
            count_nxt = count_r + slcs_pkg::COUNT_W'(1);
          end
        end
        if (bond_wr_ok_r) begin
          bond_we    = 1'b1;
          bond_waddr = bond_addr_r;
          bond_wdata = bond_rdata;
          bond_wdata[bond_sel_r] = (wval_r != 2'd0);
        end
      end
      slcs_pkg::S_RECOVER: begin
        site_rd_a_addr = rec_addr_r;
        if (recover_now) begin
          site_we    = 1'b1;
          site_waddr = rec_addr_r;
          site_wdata = slcs_pkg::ST_REM;
          count_nxt  = count_r + slcs_pkg::COUNT_W'(1);
        end
      end
      slcs_pkg::S_DONE: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: begin
        site_rd_a_addr = src_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= slcs_pkg::S_CLEAR;
      clr_r          <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      infect_prob_r  <= slcs_pkg::INFECT_PROB_RST;
      recover_prob_r <= slcs_pkg::RECOVER_PROB_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == slcs_pkg::S_CLEAR) begin
        clr_r <= clr_r + SAW'(1);
      end
      if (cfg_chan.valid) begin
        unique case (cfg_chan.data.index)
          slcs_pkg::CFG_INFECT_PROB:  infect_prob_r  <= cfg_chan.data.value;
          slcs_pkg::CFG_RECOVER_PROB: recover_prob_r <= cfg_chan.data.value;
          default:                    infect_prob_r  <= infect_prob_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= item.command;
      src_ok_r     <= src_ok;
      rec_ok_r     <= rec_ok && (item.command == slcs_pkg::CMD_STEP);
      site_wr_ok_r <= src_ok && (item.command == slcs_pkg::CMD_SITE_WRITE) &&
                      (item.write_value != slcs_pkg::ST_INVALID);
      bond_wr_ok_r <= bond_ok && (item.command == slcs_pkg::CMD_BOND_WRITE);
      wval_r       <= item.write_value;
      idraw_r      <= item.infect_draw;
      rdraw_r      <= item.recover_draw;
      src_addr_r   <= src_addr;
      nbr_addr_r   <= nbr_addr;
      rec_addr_r   <= rec_addr;
      bond_addr_r  <= bond_addr;
      bond_sel_r   <= bond_sel;
    end
    if (state_r == slcs_pkg::S_LOOKUP) begin
      inf_r      <= infect_now;
      rec_flag_r <= 1'b0;
    end
    if (state_r == slcs_pkg::S_RECOVER) begin
      rec_flag_r <= recover_now;
    end
    if ((state_r == slcs_pkg::S_DONE) && out_free) begin
      result_r.removed_count <= count_r;
      result_r.did_infect    <= inf_r;
      result_r.did_recover   <= rec_flag_r;
    end
  end

endmodule

FILE: src/slcs_port_checker.sv
// Port-level checks of the SIR lattice contact step unit, bound to the top level.
module slcs_port_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input slcs_pkg::step_result_t out_data
);

  // A stalled result keeps its value until its transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // After an item is taken, in_ready stays low in S_LOOKUP and in the state after it.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("item taken while the previous one was still in work");

  // Reset starts the memory sweep, during which no item is taken.
  assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready straight after reset");

  // A fresh result appears as the unit returns to waiting for an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while an item was still in work");

endmodule

bind sir_lattice_contact_step_unit slcs_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

FILE: verif/sir_lattice_contact_step_unit_tb.sv
// Self-checking testbench for the SIR lattice contact step unit.
module sir_lattice_contact_step_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID        = 256;
  localparam int PHASE_ITEMS = 268;
  localparam int TIMEOUT_NS  = 2_000_000;

  logic clk;
  logic rst_n;

  slcs_chan_if #(.payload_t(slcs_pkg::cfg_write_t))   cfg_chan ();
  slcs_chan_if #(.payload_t(slcs_pkg::step_item_t))   in_chan ();
  slcs_chan_if #(.payload_t(slcs_pkg::step_result_t)) out_chan ();

  sir_lattice_contact_step_unit #(
    .GRID_DIM(GRID)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the lattice, the bond store and the thresholds.
  logic [1:0]                   lattice_state [0:GRID*GRID-1] = '{default: '0};
  logic                         bond_closed   [0:2*GRID*GRID-1] = '{default: 1'b0};
  logic [slcs_pkg::COUNT_W-1:0] removed_tally = '0;
  logic [slcs_pkg::PROB_W-1:0]  infect_thr    = slcs_pkg::INFECT_PROB_RST;
  logic [slcs_pkg::PROB_W-1:0]  recover_thr   = slcs_pkg::RECOVER_PROB_RST;

  slcs_pkg::step_result_t pending_results [$];
  int fail_count     = 0;
  int items_sent     = 0;
  int settings_done  = 0;
  int infect_seen    = 0;
  int recover_seen   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d results still awaited", $time, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random back-pressure on the output channel.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    slcs_pkg::step_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, out_chan.data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.removed_count !== out_chan.data.removed_count) begin
          $display("%0t: removed_count expected %0d actual %0d", $time,
                   want.removed_count, out_chan.data.removed_count);
          fail_count++;
        end
        if (want.did_infect !== out_chan.data.did_infect) begin
          $display("%0t: did_infect expected %0b actual %0b", $time,
                   want.did_infect, out_chan.data.did_infect);
          fail_count++;
        end
        if (want.did_recover !== out_chan.data.did_recover) begin
          $display("%0t: did_recover expected %0b actual %0b", $time,
                   want.did_recover, out_chan.data.did_recover);
          fail_count++;
        end
      end
    end
  end

  // Neighbour of a site with wrap-around, and the bond between the two.
  function automatic void neighbour_of(input logic [7:0] x, input logic [7:0] y,
                                       input logic [1:0] dir,
                                       output logic [7:0] nx, output logic [7:0] ny,
                                       output logic [8:0] brow, output logic [7:0] bcol);
    nx = x;
    ny = y;
    case (dir)
      slcs_pkg::DIR_Y_INC: ny = (int'(y) + 1 >= GRID) ? 8'd0 : y + 8'd1;
      slcs_pkg::DIR_X_INC: nx = (int'(x) + 1 >= GRID) ? 8'd0 : x + 8'd1;
      slcs_pkg::DIR_Y_DEC: ny = (y == 8'd0) ? 8'(GRID - 1) : y - 8'd1;
      default:             nx = (x == 8'd0) ? 8'(GRID - 1) : x - 8'd1;
    endcase
    brow = {1'b0, x} + {1'b0, nx};
    bcol = (ny < y) ? ny : y;
  endfunction

  // Keeps the removed tally exact as sites enter or leave the removed state.
  function automatic void put_site(input int idx, input logic [1:0] v);
    if (lattice_state[idx] == slcs_pkg::ST_REM && v != slcs_pkg::ST_REM) removed_tally--;
    if (lattice_state[idx] != slcs_pkg::ST_REM && v == slcs_pkg::ST_REM) removed_tally++;
    lattice_state[idx] = v;
  endfunction

  function automatic slcs_pkg::step_result_t predict_item(input slcs_pkg::step_item_t it);
    logic [7:0]             nx, ny, bcol;
    logic [8:0]             brow;
    int                     src, nbr, rec, bidx;
    slcs_pkg::step_result_t res;
    res.did_infect  = 1'b0;
    res.did_recover = 1'b0;
    case (it.command)
      slcs_pkg::CMD_STEP: begin
        neighbour_of(it.site_x, it.site_y, it.direction, nx, ny, brow, bcol);
        src  = int'(it.site_x) * GRID + int'(it.site_y);
        nbr  = int'(nx) * GRID + int'(ny);
        bidx = int'(brow) * GRID + int'(bcol);
        if (lattice_state[src] == slcs_pkg::ST_INF &&
            lattice_state[nbr] == slcs_pkg::ST_SUS &&
            infect_thr > {1'b0, it.infect_draw} && !bond_closed[bidx]) begin
          lattice_state[nbr] = slcs_pkg::ST_INF;
          res.did_infect = 1'b1;
        end
        // Recovery comes after infection, so a freshly infected site may go too.
        rec = int'(it.recover_x) * GRID + int'(it.recover_y);
        if (lattice_state[rec] == slcs_pkg::ST_INF &&
            recover_thr > {1'b0, it.recover_draw}) begin
          put_site(rec, slcs_pkg::ST_REM);
          res.did_recover = 1'b1;
        end
      end
      slcs_pkg::CMD_SITE_WRITE: begin
        if (it.write_value != slcs_pkg::ST_INVALID)
          put_site(int'(it.site_x) * GRID + int'(it.site_y), it.write_value);
      end
      slcs_pkg::CMD_BOND_WRITE: begin
        if (int'(it.bond_row) < 2 * GRID && int'(it.bond_col) < GRID)
          bond_closed[int'(it.bond_row) * GRID + int'(it.bond_col)] = (it.write_value != 2'd0);
      end
      default: ;
    endcase
    res.removed_count = removed_tally;
    return res;
  endfunction

  // Valid is left high after a transfer so that back-to-back items need no
  // second assignment in the same step; end_input lowers it before a pause.
  task automatic send_item(input slcs_pkg::step_item_t it);
    slcs_pkg::step_result_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    do @(posedge clk); while (!in_chan.ready);
    res = predict_item(it);
    pending_results.push_back(res);
    infect_seen  += res.did_infect;
    recover_seen += res.did_recover;
    items_sent++;
  endtask

  task automatic end_input();
    in_chan.valid <= 1'b0;
  endtask

  task automatic drain_results();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_thresholds(input logic [slcs_pkg::PROB_W-1:0] inf,
                                input logic [slcs_pkg::PROB_W-1:0] rec);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= '{index: slcs_pkg::CFG_INFECT_PROB, value: inf};
    do @(posedge clk); while (!cfg_chan.ready);
    infect_thr = inf;
    cfg_chan.data <= '{index: slcs_pkg::CFG_RECOVER_PROB, value: rec};
    do @(posedge clk); while (!cfg_chan.ready);
    recover_thr = rec;
    cfg_chan.valid <= 1'b0;
    settings_done++;
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0:       begin send_idle_pct = 38; recv_idle_pct = 69; end
      1:       begin send_idle_pct = 69; recv_idle_pct = 38; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  // Coordinates cluster round the corners so that the wrap is exercised and
  // states build up densely enough for contacts to happen.
  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(0, 3));
      4, 5, 6:    return 8'($urandom_range(GRID - 4, GRID - 1));
      default:    return 8'($urandom_range(0, GRID - 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_draw(input logic [slcs_pkg::PROB_W-1:0] thr);
    logic [slcs_pkg::PROB_W-1:0] t;
    t = (thr > 17'd65535) ? 17'd65535 : thr;
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return (t == 0) ? 16'd0 : 16'(t - 1);
      3:       return 16'(t);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic slcs_pkg::step_item_t rand_item();
    slcs_pkg::step_item_t it;
    it.command      = 2'($urandom_range(0, 3));
    it.site_x       = 8'($urandom_range(0, 255));
    it.site_y       = 8'($urandom_range(0, 255));
    it.direction    = 2'($urandom_range(0, 3));
    it.infect_draw  = 16'($urandom_range(0, 65535));
    it.recover_x    = 8'($urandom_range(0, 255));
    it.recover_y    = 8'($urandom_range(0, 255));
    it.recover_draw = 16'($urandom_range(0, 65535));
    it.write_value  = 2'($urandom_range(0, 3));
    it.bond_row     = 9'($urandom_range(0, 511));
    it.bond_col     = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic send_site_write(input logic [7:0] x, input logic [7:0] y,
                                 input logic [1:0] v);
    slcs_pkg::step_item_t it;
    it = rand_item();
    it.command     = slcs_pkg::CMD_SITE_WRITE;
    it.site_x      = x;
    it.site_y      = y;
    it.write_value = v;
    send_item(it);
  endtask

  task automatic send_bond_write(input logic [8:0] row, input logic [7:0] col,
                                 input logic [1:0] v);
    slcs_pkg::step_item_t it;
    it = rand_item();
    it.command     = slcs_pkg::CMD_BOND_WRITE;
    it.bond_row    = row;
    it.bond_col    = col;
    it.write_value = v;
    send_item(it);
  endtask

  task automatic send_step(input logic [7:0] x, input logic [7:0] y, input logic [1:0] dir,
                           input logic [15:0] idraw, input logic [7:0] rx,
                           input logic [7:0] ry, input logic [15:0] rdraw);
    slcs_pkg::step_item_t it;
    it = rand_item();
    it.command      = slcs_pkg::CMD_STEP;
    it.site_x       = x;
    it.site_y       = y;
    it.direction    = dir;
    it.infect_draw  = idraw;
    it.recover_x    = rx;
    it.recover_y    = ry;
    it.recover_draw = rdraw;
    send_item(it);
  endtask

  // Contacts across the lattice edges, with the bond blocked, reblocked and opened.
  task automatic test_wrap_and_bonds();
    slcs_pkg::step_item_t it;
    send_step(8'd0, 8'd0, slcs_pkg::DIR_Y_INC, 16'd0, 8'd0, 8'd0, 16'd0);
    it = '1;
    it.command = slcs_pkg::CMD_NOP;
    send_item(it);
    send_site_write(8'd0, 8'd0, slcs_pkg::ST_INF);
    send_step(8'd0, 8'd0, slcs_pkg::DIR_Y_DEC, 16'hFFFF, 8'd0, 8'd0, 16'hFFFF);
    send_bond_write(9'd255, 8'd0, 2'd1);
    send_step(8'd0, 8'd0, slcs_pkg::DIR_X_DEC, 16'd0, 8'd255, 8'd255, 16'hFFFF);
    send_bond_write(9'd255, 8'd0, 2'd2);
    send_step(8'd0, 8'd0, slcs_pkg::DIR_X_DEC, 16'd0, 8'd255, 8'd255, 16'hFFFF);
    send_bond_write(9'd255, 8'd0, 2'd0);
    send_step(8'd0, 8'd0, slcs_pkg::DIR_X_DEC, 16'd0, 8'd255, 8'd255, 16'hFFFF);
    send_bond_write(9'd511, 8'd255, 2'd3);
    send_bond_write(9'd511, 8'd255, 2'd0);
    send_site_write(8'd255, 8'd254, slcs_pkg::ST_INF);
    send_step(8'd255, 8'd254, slcs_pkg::DIR_X_INC, 16'd1, 8'd0, 8'd0, 16'hFFFF);
  endtask

  // A neighbour infected in a step is removed in the same step; recovery at
  // the threshold and one below it.
  task automatic test_same_step_recovery();
    send_site_write(8'd128, 8'd128, slcs_pkg::ST_INF);
    send_step(8'd128, 8'd128, slcs_pkg::DIR_X_INC, 16'd0, 8'd129, 8'd128, 16'd0);
    send_step(8'd128, 8'd128, slcs_pkg::DIR_Y_INC, 16'hFFFF, 8'd128, 8'd128, 16'd13106);
    send_step(8'd0, 8'd0, slcs_pkg::DIR_Y_INC, 16'hFFFF, 8'd0, 8'd0, 16'd13107);
  endtask

  // The removed tally follows site writes; the fourth site code is ignored.
  task automatic test_site_writes();
    send_site_write(8'd128, 8'd128, slcs_pkg::ST_INVALID);
    send_site_write(8'd128, 8'd128, slcs_pkg::ST_SUS);
    send_site_write(8'd129, 8'd128, slcs_pkg::ST_REM);
    send_site_write(8'd5, 8'd5, slcs_pkg::ST_REM);
  endtask

  // Mostly well-formed contacts: infect a source, shape its neighbour and
  // bond, then step; the rest is loose random traffic.
  task automatic send_contact_burst();
    logic [7:0] sx, sy, nx, ny, bcol, rx, ry;
    logic [8:0] brow;
    logic [1:0] dir;
    sx  = pick_coord();
    sy  = pick_coord();
    dir = 2'($urandom_range(0, 3));
    neighbour_of(sx, sy, dir, nx, ny, brow, bcol);
    if ($urandom_range(0, 3) != 0) send_site_write(sx, sy, slcs_pkg::ST_INF);
    if ($urandom_range(0, 2) == 0) send_site_write(nx, ny, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 3) == 0) send_bond_write(brow, bcol, 2'($urandom_range(0, 3)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin rx = nx; ry = ny; end
      4, 5, 6:    begin rx = sx; ry = sy; end
      default:    begin rx = pick_coord(); ry = pick_coord(); end
    endcase
    send_step(sx, sy, dir, pick_draw(infect_thr), rx, ry, pick_draw(recover_thr));
  endtask

  task automatic test_threshold_sweep();
    logic [slcs_pkg::PROB_W-1:0] inf_set [0:6];
    logic [slcs_pkg::PROB_W-1:0] rec_set [0:6];
    slcs_pkg::step_item_t        it;
    int                          target;
    inf_set = '{17'd65536, 17'd0, 17'd1, 17'd65535, 17'd32768, 17'd0, 17'd0};
    rec_set = '{17'd13107, 17'd65536, 17'd0, 17'd65535, 17'd2000, 17'd0, 17'd0};
    for (int p = 5; p < 7; p++) begin
      inf_set[p] = 17'($urandom_range(0, 65536));
      rec_set[p] = 17'($urandom_range(0, 65536));
    end
    for (int p = 0; p < 7; p++) begin
      end_input();
      drain_results();
      set_thresholds(inf_set[p], rec_set[p]);
      set_idle_mode((p < 3) ? 0 : (p < 5) ? 1 : 2);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 55) begin
          send_contact_burst();
        end else begin
          it = rand_item();
          if ($urandom_range(0, 1) == 0) begin
            it.site_x    = pick_coord();
            it.site_y    = pick_coord();
            it.recover_x = pick_coord();
            it.recover_y = pick_coord();
          end
          send_item(it);
        end
        if ($urandom_range(0, 149) == 0) begin
          end_input();
          drain_results();
        end
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.data   <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data  <= '{index: slcs_pkg::CFG_INFECT_PROB, value: '0};
    set_idle_mode(0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_wrap_and_bonds();
    test_same_step_recovery();
    test_site_writes();
    test_threshold_sweep();

    end_input();
    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d items over %0d threshold settings and three idle patterns.",
             items_sent, settings_done);
    $display("Predicted %0d infections and %0d recoveries; final removed tally %0d.",
             infect_seen, recover_seen, removed_tally);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sir_lattice_contact_step_unit.f
src/slcs_pkg.sv
src/slcs_chan_if.sv
src/slcs_lattice_store.sv
src/sir_lattice_contact_step_unit.sv
src/slcs_port_checker.sv
verif/sir_lattice_contact_step_unit_tb.sv
